FILE: sv/l2g_pkg.sv
`default_nettype none

package l2g_pkg;

	// Fixed arithmetic of the grey value and the level scale.
	localparam int LEVELS       = 24;
	localparam int LVL_W        = 5;
	localparam int LUMA_W       = 18;
	localparam int GREY_W       = 26;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int Y_W          = 12;
	localparam logic [GREY_W-1:0] GREY_FULL = 26'd65025000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SET    = 3'd5;
	localparam int CFG_DATA_W = 13;

	// Two glyph sets, darkest first, as ASCII codes.
	localparam logic [7:0] GLYPH_ROM [2][LEVELS] = '{
		'{8'h20, 8'h60, 8'h27, 8'h2E, 8'h3A, 8'h3B, 8'h2D, 8'h7E,
		  8'h22, 8'h3C, 8'h2B, 8'h2A, 8'h75, 8'h6F, 8'h78, 8'h61,
		  8'h4E, 8'h26, 8'h38, 8'h24, 8'h25, 8'h23, 8'h57, 8'h40},
		'{8'h20, 8'h60, 8'h27, 8'h2E, 8'h2D, 8'h7E, 8'h22, 8'h3A,
		  8'h3B, 8'h3C, 8'h2B, 8'h2A, 8'h75, 8'h6F, 8'h78, 8'h61,
		  8'h4E, 8'h26, 8'h38, 8'h24, 8'h25, 8'h23, 8'h57, 8'h40}
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       glyph;
		logic [LVL_W-1:0] level;
		logic             row_end;
		logic             image_end;
	} glyph_out_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [12:0] image_height;
		logic [6:0]  block_width;
		logic [6:0]  block_height;
		logic        invert;
		logic        glyph_set;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic luma;
		logic grey;
		logic acc;
		logic den_init;
		logic step;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic block_done;
		logic search_more;
	} ctrl_sts_t;

endpackage

`default_nettype wire

FILE: sv/l2g_ram.sv
`default_nettype none

module l2g_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/l2g_ctrl.sv
`default_nettype none

module l2g_ctrl import l2g_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LUMA = 6'b000010,
		S_GREY = 6'b000100,
		S_ACC  = 6'b001000,
		S_DEN  = 6'b010000,
		S_SRCH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_busy;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The output register can take a new beat in the cycle its old beat leaves.
	assign out_busy  = out_valid_q && !out_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LUMA;
				end
			end
			S_LUMA: begin
				cmd.luma = 1'b1;
				state_d  = S_GREY;
			end
			S_GREY: begin
				cmd.grey = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.block_done ? S_DEN : S_IDLE;
			end
			S_DEN: begin
				cmd.den_init = 1'b1;
				state_d      = S_SRCH;
			end
			S_SRCH: begin
				if (sts.search_more) begin
					cmd.step = 1'b1;
				end else if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/l2g_dp.sv
`default_nettype none

module l2g_dp import l2g_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire ctrl_cmd_t cmd,
	output ctrl_sts_t      sts,
	input  wire pixel_t    in_data,
	output glyph_out_t     out_data
);

	localparam int X_W   = $clog2(MAX_WIDTH);
	localparam int B_W   = $clog2(MAX_BLOCK);
	localparam int CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
	localparam int SUM_W = GREY_W + CNT_W;
	localparam int NUM_W = SUM_W + LVL_W;
	localparam int ENT_W = CNT_W + SUM_W;

	// Register value minus one, with zero acting as one and a ceiling of hi.
	function automatic int clamp_m1(int v, int hi);
		int r;
		if (v == 0) begin
			r = 0;
		end else if (v > hi) begin
			r = hi - 1;
		end else begin
			r = v - 1;
		end
		return r;
	endfunction

	pixel_t            pix_q;
	logic [LUMA_W-1:0] luma_q;
	logic [GREY_W-1:0] grey_q;
	logic [X_W-1:0]    px_q, bcol_q;
	logic [Y_W-1:0]    py_q;
	logic [B_W-1:0]    rib_q, cib_q;
	logic [SUM_W-1:0]  sum_q, den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              xl_q, yl_q;
	logic [NUM_W-1:0]  num_q, thr_q;
	logic [LVL_W-1:0]  lvl_q;
	glyph_out_t        out_q;

	logic [X_W-1:0]    wm1, bc;
	logic [Y_W-1:0]    hm1;
	logic [B_W-1:0]    bwm1, bhm1;
	logic              x_last, y_last, col_last, row_last, first;
	logic [ENT_W-1:0]  rd_ent, wr_ent;
	logic [SUM_W-1:0]  rd_sum, new_sum;
	logic [CNT_W-1:0]  rd_cnt, new_cnt, n_eff;
	logic [SUM_W-1:0]  den;
	logic [LVL_W-1:0]  lvl_out;

	// Limits of the current geometry.
	assign wm1  = X_W'(clamp_m1(32'(cfg.image_width), MAX_WIDTH));
	assign hm1  = Y_W'(clamp_m1(32'(cfg.image_height), HEIGHT_LIMIT));
	assign bwm1 = B_W'(clamp_m1(32'(cfg.block_width), MAX_BLOCK));
	assign bhm1 = B_W'(clamp_m1(32'(cfg.block_height), MAX_BLOCK));

	// Position tests; >= closes a block at once if the limits shrink.
	assign x_last   = (px_q >= wm1);
	assign y_last   = (py_q >= hm1);
	assign col_last = x_last || (cib_q >= bwm1);
	assign row_last = y_last || (rib_q >= bhm1);
	assign first    = (rib_q == '0) && (cib_q == '0);
	assign bc       = ({1'b0, bcol_q} >= (X_W + 1)'(MAX_WIDTH - 1)) ?
	                  X_W'(MAX_WIDTH - 1) : bcol_q;

	// Column accumulators: pixel count over running sum.
	l2g_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_WIDTH)
	) u_col_ram (
		.clk   (clk),
		.we    (cmd.acc),
		.waddr (bc),
		.wdata (wr_ent),
		.re    (cmd.luma),
		.raddr (bc),
		.rdata (rd_ent)
	);

	assign rd_sum  = rd_ent[SUM_W-1:0];
	assign rd_cnt  = rd_ent[ENT_W-1:SUM_W];
	assign new_sum = first ? SUM_W'(grey_q) : rd_sum + SUM_W'(grey_q);
	assign new_cnt = first ? CNT_W'(1) : rd_cnt + CNT_W'(1);
	assign wr_ent  = {new_cnt, new_sum};

	// Denominator of the mean: pixel count times full-scale grey.
	assign n_eff = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
	assign den   = SUM_W'(n_eff) * SUM_W'(GREY_FULL);

	assign sts.block_done  = col_last && row_last;
	assign sts.search_more = (num_q > thr_q) && (lvl_q < LVL_W'(LEVELS - 1));

	assign lvl_out  = cfg.invert ? LVL_W'(LEVELS - 1) - lvl_q : lvl_q;
	assign out_data = out_q;

	// Pixel capture, luma and grey stages.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= in_data;
		end
		if (cmd.luma) begin
			luma_q <= LUMA_W'(pix_q.red) * LUMA_W'(299)
			        + LUMA_W'(pix_q.green) * LUMA_W'(587)
			        + LUMA_W'(pix_q.blue) * LUMA_W'(114);
		end
		if (cmd.grey) begin
			grey_q <= GREY_W'(luma_q) * GREY_W'(pix_q.alpha);
		end
	end

	// Raster position; a frame start moves it to the origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			rib_q  <= '0;
			cib_q  <= '0;
			bcol_q <= '0;
		end else if (cmd.load && in_data.frame_start) begin
			px_q   <= '0;
			py_q   <= '0;
			rib_q  <= '0;
			cib_q  <= '0;
			bcol_q <= '0;
		end else if (cmd.acc) begin
			if (x_last) begin
				px_q   <= '0;
				cib_q  <= '0;
				bcol_q <= '0;
				if (y_last) begin
					py_q  <= '0;
					rib_q <= '0;
				end else begin
					py_q  <= py_q + Y_W'(1);
					rib_q <= row_last ? '0 : rib_q + B_W'(1);
				end
			end else begin
				px_q <= px_q + X_W'(1);
				if (col_last) begin
					cib_q  <= '0;
					bcol_q <= bc + X_W'(1);
				end else begin
					cib_q <= cib_q + B_W'(1);
				end
			end
		end
	end

	// Block result and level search: smallest level whose threshold covers the mean.
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			sum_q <= new_sum;
			cnt_q <= new_cnt;
			xl_q  <= x_last;
			yl_q  <= y_last;
		end
		if (cmd.den_init) begin
			num_q <= NUM_W'(sum_q) * NUM_W'(LEVELS);
			den_q <= den;
			thr_q <= NUM_W'(den);
			lvl_q <= '0;
		end else if (cmd.step) begin
			thr_q <= thr_q + NUM_W'(den_q);
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.out_load) begin
			out_q.glyph     <= GLYPH_ROM[cfg.glyph_set][lvl_out];
			out_q.level     <= lvl_out;
			out_q.row_end   <= xl_q;
			out_q.image_end <= xl_q && yl_q;
		end
	end

endmodule

`default_nettype wire

FILE: sv/block_luma_to_glyph.sv
`default_nettype none

// Channel   Signals                                   Beat
// in        in_valid, in_ready, in_data (pixel_t)      one RGBA pixel, raster order
// out       out_valid, out_ready, out_data             one glyph per finished block
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  one register write
//
// A pixel that does not finish a block passes through capture, luma with
// accumulator read, grey, and accumulator write-back.
// A pixel that finishes a block then sets up the denominator and runs the
// level search, which adds one threshold step per cycle until it finds the
// level before inversion.
// Reset restores the register defaults and moves the position to the origin;
// accumulators are started by the first pixel of each block.
// A result waiting in the output register stalls the block only at the end of
// the next level search; pixels are taken meanwhile.

module block_luma_to_glyph import l2g_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire pixel_t                in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output glyph_out_t                 out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 11'd640;
			cfg_q.image_height <= 13'd480;
			cfg_q.block_width  <= 7'd8;
			cfg_q.block_height <= 7'd16;
			cfg_q.invert       <= 1'b0;
			cfg_q.glyph_set    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[12:0];
				CFG_BLOCK_WIDTH:  cfg_q.block_width  <= cfg_data[6:0];
				CFG_BLOCK_HEIGHT: cfg_q.block_height <= cfg_data[6:0];
				CFG_INVERT:       cfg_q.invert       <= cfg_data[0];
				CFG_GLYPH_SET:    cfg_q.glyph_set    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	l2g_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	l2g_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (out_data)
	);

`ifndef ASSERT_OFF
	// No pixel is accepted in the cycle after one was accepted.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("pixel accepted while the previous one is in progress");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register loaded while occupied");

	// The level stays on the scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.level <= LVL_W'(LEVELS - 1)))
		else $error("level beyond the scale");

	// The last block of an image is also last in its block row.
	a_image_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.image_end || out_data.row_end))
		else $error("image end without row end");
`endif

endmodule

`default_nettype wire

FILE: sim/glyph_checker.sv
`timescale 1ns / 1ps

module glyph_checker import l2g_pkg::*; #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_SIDE = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire pixel_t                in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire glyph_out_t            out_data,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned                fail_count,
	output int unsigned                pending,
	output int unsigned                checked
);

	localparam int unsigned     SHADES     = 24;
	localparam int unsigned     ROW_LIMIT  = 4096;
	localparam longint unsigned FULL_GREY  = 64'd65025000;

	// Both character sets, darkest first; element [0][0] is the leftmost byte.
	localparam bit [0:1][0:SHADES-1][7:0] CHARSET = {
		8'h20, 8'h60, 8'h27, 8'h2E, 8'h3A, 8'h3B, 8'h2D, 8'h7E,
		8'h22, 8'h3C, 8'h2B, 8'h2A, 8'h75, 8'h6F, 8'h78, 8'h61,
		8'h4E, 8'h26, 8'h38, 8'h24, 8'h25, 8'h23, 8'h57, 8'h40,
		8'h20, 8'h60, 8'h27, 8'h2E, 8'h2D, 8'h7E, 8'h22, 8'h3A,
		8'h3B, 8'h3C, 8'h2B, 8'h2A, 8'h75, 8'h6F, 8'h78, 8'h61,
		8'h4E, 8'h26, 8'h38, 8'h24, 8'h25, 8'h23, 8'h57, 8'h40
	};

	// Shadow of the register file and of the block's position and accumulators.
	cfg_t            shadow;
	longint unsigned blk_sum [MAX_COLS];
	int unsigned     blk_cnt [MAX_COLS];
	int unsigned     pos_x, pos_y, row_in, col_in, blk_col;
	glyph_out_t      due_glyphs [$];
	int unsigned     n_fail, n_seen;

	// A zero size acts as one and an oversized one saturates.
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Accumulates one pixel and queues the glyph of any block that it closes.
	function automatic void predict_glyph(input pixel_t px);
		int unsigned     w, h, bw, bh, bc;
		longint unsigned grey, den, q, lvl;
		bit              x_last, y_last, col_last, row_last;
		glyph_out_t      g;
		w  = clamp_dim(shadow.image_width, MAX_COLS);
		h  = clamp_dim(shadow.image_height, ROW_LIMIT);
		bw = clamp_dim(shadow.block_width, MAX_SIDE);
		bh = clamp_dim(shadow.block_height, MAX_SIDE);
		grey = (64'd299 * px.red + 64'd587 * px.green + 64'd114 * px.blue) * px.alpha;

		if (px.frame_start) begin
			pos_x = 0;
			pos_y = 0;
			row_in = 0;
			col_in = 0;
			blk_col = 0;
		end
		bc = (blk_col >= MAX_COLS) ? MAX_COLS - 1 : blk_col;

		// The first pixel of a block restarts its column accumulator.
		if (row_in == 0 && col_in == 0) begin
			blk_sum[bc] = grey;
			blk_cnt[bc] = 1;
		end else begin
			blk_sum[bc] += grey;
			blk_cnt[bc] += 1;
		end

		x_last   = pos_x >= w - 1;
		y_last   = pos_y >= h - 1;
		col_last = x_last || col_in >= bw - 1;
		row_last = y_last || row_in >= bh - 1;

		// Level is the smallest k with mean <= (k+1)/24, found by exact division.
		if (col_last && row_last) begin
			den = ((blk_cnt[bc] == 0) ? 64'd1 : blk_cnt[bc]) * FULL_GREY;
			q   = (SHADES * blk_sum[bc] + den - 1) / den;
			lvl = (q == 0) ? 0 : q - 1;
			if (lvl > SHADES - 1)
				lvl = SHADES - 1;
			if (shadow.invert)
				lvl = SHADES - 1 - lvl;
			g.glyph     = CHARSET[shadow.glyph_set][lvl];
			g.level     = LVL_W'(lvl);
			g.row_end   = x_last;
			g.image_end = x_last && y_last;
			due_glyphs  = {due_glyphs, g};
		end

		// Advance the raster position.
		if (x_last) begin
			pos_x = 0;
			col_in = 0;
			blk_col = 0;
			if (y_last) begin
				pos_y = 0;
				row_in = 0;
			end else begin
				pos_y++;
				row_in = row_last ? 0 : row_in + 1;
			end
		end else begin
			pos_x++;
			if (col_last) begin
				col_in = 0;
				blk_col = bc + 1;
			end else begin
				col_in++;
			end
		end
	endfunction

	// Output beats are checked before the pixel of the same edge is predicted,
	// so that a glyph cannot be matched against its own pixel.
	always @(posedge clk or negedge arst_n) begin
		glyph_out_t want;
		if (!arst_n) begin
			shadow  = cfg_t'{11'd640, 13'd480, 7'd8, 7'd16, 1'b0, 1'b0};
			pos_x   = 0;
			pos_y   = 0;
			row_in  = 0;
			col_in  = 0;
			blk_col = 0;
			n_fail  = 0;
			n_seen  = 0;
			due_glyphs.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_glyphs.size() == 0) begin
					$display("%0t: expected no glyph, got glyph %02h level %0d row_end %0b image_end %0b",
						$time, out_data.glyph, out_data.level, out_data.row_end,
						out_data.image_end);
					n_fail++;
				end else begin
					want = due_glyphs.pop_front();
					n_seen++;
					if (out_data.glyph !== want.glyph || out_data.level !== want.level ||
						out_data.row_end !== want.row_end ||
						out_data.image_end !== want.image_end) begin
						$display("%0t: expected glyph %02h level %0d row_end %0b image_end %0b, %s",
							$time, want.glyph, want.level, want.row_end, want.image_end,
							$sformatf("got glyph %02h level %0d row_end %0b image_end %0b",
								out_data.glyph, out_data.level, out_data.row_end,
								out_data.image_end));
						n_fail++;
					end
				end
			end

			// Register writes are kept at the width of each register.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  shadow.image_width  = cfg_data[10:0];
					CFG_IMAGE_HEIGHT: shadow.image_height = cfg_data[12:0];
					CFG_BLOCK_WIDTH:  shadow.block_width  = cfg_data[6:0];
					CFG_BLOCK_HEIGHT: shadow.block_height = cfg_data[6:0];
					CFG_INVERT:       shadow.invert       = cfg_data[0];
					CFG_GLYPH_SET:    shadow.glyph_set    = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				predict_glyph(in_data);

			fail_count <= n_fail;
			pending    <= due_glyphs.size();
			checked    <= n_seen;
		end
	end

endmodule

FILE: sim/tb_block_luma_to_glyph.sv
`timescale 1ns / 1ps

module tb_block_luma_to_glyph import l2g_pkg::*; ();

	localparam int unsigned WIDTH_LIMIT = 1024;
	localparam int unsigned SIDE_LIMIT  = 64;
	localparam int unsigned ITEMS       = 1600;
	localparam int unsigned GAP_MAX     = 12;
	localparam int unsigned DRAIN       = 64;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam bit [5:0]    ALL_REGS    = 6'b111111;

	typedef enum int unsigned {SHADE_NOISE, SHADE_FLAT, SHADE_HARD} shade_e;
	typedef enum int unsigned {
		SHAPE_SMALL, SHAPE_BLOCK_EDGE, SHAPE_WIDE, SHAPE_TALL, SHAPE_FLOOD
	} shape_e;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	pixel_t                in_data;
	logic                  out_valid;
	logic                  out_ready;
	glyph_out_t            out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count, pending, checked;
	int unsigned pixels_sent, settings_run;
	bit          src_idle, sink_idle, hold_req;
	cfg_t        cur_cfg;

	block_luma_to_glyph u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	glyph_checker #(
		.MAX_COLS (WIDTH_LIMIT),
		.MAX_SIDE (SIDE_LIMIT)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// 125 MHz clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d glyphs outstanding.", cycles, pending);
		$display("*** FAILED ***");
		$finish;
	end

	// Glyph receiver: a random stall after each beat when sink_idle is set, or one long hold-off on request.
	initial begin : sink
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req  <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (out_valid && out_ready) begin
				stall = sink_idle ? $urandom_range(GAP_MAX, 0) : 0;
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// A channel value close to the tone of the image.
	function automatic logic [7:0] shade_near(input int unsigned base);
		int v;
		v = int'(base) + int'($urandom_range(16, 0)) - 8;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic pixel_t make_pixel(input shade_e shade, input int unsigned base,
		input bit fs);
		pixel_t px;
		case (shade)
			SHADE_FLAT: begin
				px.red   = shade_near(base);
				px.green = shade_near(base);
				px.blue  = shade_near(base);
				px.alpha = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0)) : 8'hFF;
			end
			SHADE_HARD: begin
				px.red   = $urandom_range(1, 0) ? 8'hFF : 8'h00;
				px.green = $urandom_range(1, 0) ? 8'hFF : 8'h00;
				px.blue  = $urandom_range(1, 0) ? 8'hFF : 8'h00;
				px.alpha = $urandom_range(1, 0) ? 8'hFF : 8'h00;
			end
			default: begin
				{px.red, px.green, px.blue, px.alpha} = $urandom;
			end
		endcase
		px.frame_start = fs;
		return px;
	endfunction

	// One side of a block at or beyond its limits.
	function automatic logic [6:0] edge_side();
		case ($urandom_range(3, 0))
			0:       return 7'd0;
			1:       return 7'd1;
			2:       return 7'd64;
			default: return 7'($urandom_range(127, 65));
		endcase
	endfunction

	function automatic cfg_t pick_cfg(input shape_e shape);
		cfg_t c;
		c.invert    = 1'($urandom_range(1, 0));
		c.glyph_set = 1'($urandom_range(1, 0));
		case (shape)
			SHAPE_WIDE: begin
				c.image_width  = 11'($urandom_range(2047, 1024));
				c.image_height = 13'd1;
				c.block_width  = 7'($urandom_range(64, 16));
				c.block_height = 7'($urandom_range(2, 1));
			end
			SHAPE_TALL: begin
				c.image_width  = 11'($urandom_range(2, 1));
				c.image_height = 13'($urandom_range(8191, 4096));
				c.block_width  = 7'($urandom_range(2, 0));
				c.block_height = 7'($urandom_range(127, 64));
			end
			SHAPE_FLOOD: begin
				c.image_width  = 11'd8;
				c.image_height = 13'd6;
				c.block_width  = 7'd1;
				c.block_height = 7'd1;
			end
			SHAPE_BLOCK_EDGE: begin
				c.image_width  = 11'($urandom_range(12, 1));
				c.image_height = 13'($urandom_range(6, 1));
				c.block_width  = edge_side();
				c.block_height = edge_side();
			end
			default: begin
				c.image_width  = 11'($urandom_range(16, 0));
				c.image_height = 13'($urandom_range(8, 0));
				c.block_width  = 7'($urandom_range(8, 0));
				c.block_height = 7'($urandom_range(8, 0));
			end
		endcase
		return c;
	endfunction

	// Writes the registers selected by the mask; valid stays high between beats.
	task automatic write_regs(input cfg_t c, input bit [5:0] mask);
		int unsigned           i;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		for (i = 0; i < 6; i++) begin
			if (mask[i]) begin
				idx = CFG_IDX_W'(i);
				case (idx)
					CFG_IMAGE_WIDTH:  val = CFG_DATA_W'(c.image_width);
					CFG_IMAGE_HEIGHT: val = CFG_DATA_W'(c.image_height);
					CFG_BLOCK_WIDTH:  val = CFG_DATA_W'(c.block_width);
					CFG_BLOCK_HEIGHT: val = CFG_DATA_W'(c.block_height);
					CFG_INVERT:       val = CFG_DATA_W'(c.invert);
					default:          val = CFG_DATA_W'(c.glyph_set);
				endcase
				cfg_valid <= 1'b1;
				cfg_index <= idx;
				cfg_data  <= val;
				do @(posedge clk); while (!cfg_ready);
			end
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
		settings_run++;
	endtask

	task automatic send_pixel(input pixel_t px);
		int unsigned gap;
		gap = src_idle ? $urandom_range(GAP_MAX, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	// Stops offering pixels until every glyph has arrived and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Images at the current setting, each with one shading style and at most cap pixels, with stray frame starts.
	task automatic send_images(input int unsigned n_img, input int unsigned cap);
		int unsigned w, h, npx, img, k, base;
		shade_e      shade;
		bit          fs;
		w = eff_dim(cur_cfg.image_width, WIDTH_LIMIT);
		h = eff_dim(cur_cfg.image_height, HEIGHT_LIMIT);
		for (img = 0; img < n_img; img++) begin
			shade = shade_e'($urandom_range(2, 0));
			base  = $urandom_range(255, 0);
			npx   = w * h;
			if (npx > cap)
				npx = cap;
			// The last image is sometimes cut short; the next setting starts a new frame.
			if (img == n_img - 1 && $urandom_range(3, 0) == 0)
				npx = $urandom_range(npx, 1);
			for (k = 0; k < npx; k++) begin
				if (k == 0)
					fs = (img == 0) || ($urandom_range(1, 0) == 1);
				else
					fs = ($urandom_range(99, 0) == 0);
				send_pixel(make_pixel(shade, base, fs));
			end
		end
	endtask

	initial begin : stimulus
		cfg_t        c;
		shape_e      shape;
		int unsigned phase, start;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= '0;
		hold_req  <= 1'b0;
		arst_n    <= 1'b0;
		src_idle     = 1'b1;
		sink_idle    = 1'b1;
		pixels_sent  = 0;
		settings_run = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-pixel blocks: black, white, primaries, half and zero opacity,
		// and a frame start in the middle of an image.
		write_regs(cfg_t'{11'd2, 13'd2, 7'd1, 7'd1, 1'b0, 1'b0}, ALL_REGS);
		send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
		send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
		send_pixel(pixel_t'{8'd255, 8'd0, 8'd0, 8'd255, 1'b1});
		send_pixel(pixel_t'{8'd0, 8'd0, 8'd255, 8'd128, 1'b0});
		send_pixel(pixel_t'{8'd0, 8'd255, 8'd0, 8'd255, 1'b0});
		send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0, 1'b0});
		settle();

		// Zero sizes act as one; inverted levels from the second set.
		write_regs(cfg_t'{11'd0, 13'd0, 7'd0, 7'd0, 1'b1, 1'b1}, ALL_REGS);
		send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
		send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255, 1'b0});
		send_pixel(pixel_t'{8'd128, 8'd128, 8'd128, 8'd255, 1'b0});
		settle();

		// Saturated block sizes: the whole small image is one partial block.
		write_regs(cfg_t'{11'd3, 13'd2, 7'd127, 7'd127, 1'b0, 1'b1}, ALL_REGS);
		send_images(1, 6);
		settle();

		// Heights reduced part way through a block row close it at once.
		write_regs(cfg_t'{11'd4, 13'd4, 7'd2, 7'd3, 1'b1, 1'b0}, ALL_REGS);
		send_pixel(make_pixel(SHADE_NOISE, 0, 1'b1));
		repeat (4) send_pixel(make_pixel(SHADE_NOISE, 0, 1'b0));
		settle();
		c = cur_cfg;
		c.image_height = 13'd2;
		c.block_height = 7'd1;
		write_regs(c, (6'd1 << CFG_IMAGE_HEIGHT) | (6'd1 << CFG_BLOCK_HEIGHT));
		repeat (3) send_pixel(make_pixel(SHADE_NOISE, 0, 1'b0));
		settle();

		// Random settings, each starting with a new frame.
		start = pixels_sent;
		phase = 0;
		while (pixels_sent - start < ITEMS) begin
			case (phase)
				1:       shape = SHAPE_FLOOD;
				3:       shape = SHAPE_WIDE;
				5:       shape = SHAPE_TALL;
				default: shape = ($urandom_range(4, 0) == 0) ? SHAPE_BLOCK_EDGE : SHAPE_SMALL;
			endcase
			write_regs(pick_cfg(shape), ALL_REGS);
			src_idle  = ($urandom_range(3, 0) != 0);
			sink_idle = ($urandom_range(3, 0) != 0);
			case (shape)
				SHAPE_FLOOD: begin
					// Every pixel is a glyph while the receiver holds off.
					src_idle = 1'b0;
					hold_req <= 1'b1;
					send_images(1, 64);
				end
				SHAPE_WIDE: send_images(1, WIDTH_LIMIT);
				SHAPE_TALL: send_images(1, 200);
				default:    send_images($urandom_range(3, 1), 128);
			endcase
			settle();
			phase++;
		end

		$display("Summary: %0d pixels over %0d register settings, %0d glyphs compared.",
			pixels_sent, settings_run, checked);
		$display("Covered: zero to saturated sizes, full-width rows, tall frames, long output stall.");
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
